/* hw/rtl/jls_pkg.sv */
// Shared constants and types for the Jacobi Laplace stencil sweep.
`default_nettype none

package jls_pkg;

   localparam int MAX_COLS_DEFAULT  = 1022;
   localparam int MAX_ROWS_DEFAULT  = 4095;
   localparam int CELL_BITS_DEFAULT = 24;

   localparam int COLS_RESET      = 1022;
   localparam int ROWS_RESET      = 1022;
   localparam int THRESHOLD_RESET = 655;

   localparam int CSR_INDEX_BITS = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_COLS      = 2'd0,
      CSR_ROWS      = 2'd1,
      CSR_THRESHOLD = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic emit;
      logic last;
      logic restart;
   } cell_flags_type;

endpackage

`default_nettype wire

/* hw/rtl/jls_point_update.sv */
// Four-neighbour average, absolute change, running maximum and convergence test.
`default_nettype none

module jls_point_update #(
   parameter int CELL_BITS = jls_pkg::CELL_BITS_DEFAULT
) (
   input  wire logic [CELL_BITS-1:0]   up_value,
   input  wire logic [CELL_BITS-1:0]   down_value,
   input  wire logic [CELL_BITS-1:0]   left_value,
   input  wire logic [CELL_BITS-1:0]   right_value,
   input  wire logic [CELL_BITS-1:0]   centre_value,
   input  wire logic [CELL_BITS-1:0]   running_max,
   input  wire logic [CELL_BITS-1:0]   threshold,
   input  wire jls_pkg::cell_flags_type flags,
   output logic      [CELL_BITS-1:0]   new_value,
   output logic      [CELL_BITS-1:0]   cell_change,
   output logic      [CELL_BITS-1:0]   max_next,
   output logic                        converged
);
   import jls_pkg::*;

   logic [CELL_BITS+1:0] sum;
   logic [CELL_BITS-1:0] base_max;

   always_comb begin
      sum = {2'b00, up_value} + {2'b00, down_value}
          + {2'b00, left_value} + {2'b00, right_value};
      new_value = sum[CELL_BITS+1:2];
      if (new_value >= centre_value) begin
         cell_change = new_value - centre_value;
      end else begin
         cell_change = centre_value - new_value;
      end
      base_max = flags.restart ? '0 : running_max;
      if (flags.emit && (cell_change > base_max)) begin
         max_next = cell_change;
      end else begin
         max_next = base_max;
      end
      converged = flags.last && (max_next <= threshold);
   end

endmodule

`default_nettype wire

/* hw/rtl/jacobi_laplace_stencil_sweep.sv */
// Top level of the streaming Jacobi five-point Laplace sweep.
`default_nettype none

// Takes the padded grid in raster order, one cell per request, and returns one
// result per interior cell: the truncated four-neighbour average, its absolute
// change, the sweep's running maximum change and, on the last interior cell, a
// converged flag. Sustained rate is one request per cycle unless a stalled result
// holds the update stage; each result passes the update stage and the result
// register. Two line memories (one write and up to two reads per cycle, registered
// reads) hold the rows above; the line store write-back is forwarded to an
// overlapping read. Line memories are not cleared: a sweep starts with first_cell
// at the top-left padded cell and the first sweep after a widening fills them.
module jacobi_laplace_stencil_sweep #(
   parameter int MAX_COLS  = jls_pkg::MAX_COLS_DEFAULT,
   parameter int MAX_ROWS  = jls_pkg::MAX_ROWS_DEFAULT,
   parameter int CELL_BITS = jls_pkg::CELL_BITS_DEFAULT,
   localparam int COL_BITS = $clog2(MAX_COLS + 1),
   localparam int ROW_BITS = $clog2(MAX_ROWS + 1),
   localparam int CR_BITS  = (COL_BITS > ROW_BITS) ? COL_BITS : ROW_BITS,
   localparam int CSR_BITS = (CR_BITS > CELL_BITS) ? CR_BITS : CELL_BITS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write_enable,
   input  wire logic [jls_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_BITS-1:0]                csr_write_data,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [CELL_BITS-1:0]               req_cell_value,
   input  wire logic                               req_first_cell,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic      [CELL_BITS-1:0]               rsp_new_value,
   output logic      [CELL_BITS-1:0]               rsp_cell_change,
   output logic      [ROW_BITS-1:0]                rsp_row_index,
   output logic      [COL_BITS-1:0]                rsp_col_index,
   output logic      [CELL_BITS-1:0]               rsp_max_change,
   output logic                                    rsp_last_of_sweep,
   output logic                                    rsp_converged
);
   import jls_pkg::*;

   localparam int LINE_DEPTH = MAX_COLS + 2;
   localparam int POS_BITS   = $clog2(LINE_DEPTH);
   localparam int WIDE_BITS  = POS_BITS + 1;
   localparam int RPOS_BITS  = $clog2(MAX_ROWS + 3);

   // configuration
   logic [COL_BITS-1:0]  cols_ff;
   logic [ROW_BITS-1:0]  rows_ff;
   logic [CELL_BITS-1:0] threshold_ff;
   logic [COL_BITS-1:0]  cols_eff;
   logic [ROW_BITS-1:0]  rows_eff;
   logic [WIDE_BITS-1:0] width_pad;
   logic [RPOS_BITS-1:0] height_pad;

   // position
   logic [POS_BITS-1:0]  col_ff, col_in;
   logic [RPOS_BITS-1:0] row_ff, row_in;
   logic [POS_BITS-1:0]  col0;
   logic [RPOS_BITS-1:0] row0;
   logic [WIDE_BITS-1:0] col_inc;
   logic                 wrap;
   logic                 live;
   logic                 accept;
   logic                 enter;
   cell_flags_type       flags_now;

   // line memories and read registers
   logic [CELL_BITS-1:0] line_one_mem [LINE_DEPTH];
   logic [CELL_BITS-1:0] line_two_mem [LINE_DEPTH];
   logic [CELL_BITS-1:0] mid_rd_ff;
   logic [CELL_BITS-1:0] right_rd_ff;
   logic [CELL_BITS-1:0] up_rd_ff;
   logic                 fwd_hit_ff;
   logic [CELL_BITS-1:0] fwd_data_ff;
   logic [CELL_BITS-1:0] up_value;

   // update stage
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_fire;
   logic [POS_BITS-1:0]  s1_col_ff;
   logic [ROW_BITS-1:0]  s1_row_index_ff;
   logic [CELL_BITS-1:0] s1_cell_ff;
   cell_flags_type       s1_flags_ff;
   logic [CELL_BITS-1:0] left_ff, left_in;
   logic [CELL_BITS-1:0] running_max_ff, running_max_in;
   logic [CELL_BITS-1:0] new_value;
   logic [CELL_BITS-1:0] cell_change;
   logic [CELL_BITS-1:0] max_next;
   logic                 converged;

   // result register
   logic                 out_free;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CELL_BITS-1:0] rsp_new_value_ff;
   logic [CELL_BITS-1:0] rsp_cell_change_ff;
   logic [ROW_BITS-1:0]  rsp_row_index_ff;
   logic [COL_BITS-1:0]  rsp_col_index_ff;
   logic [CELL_BITS-1:0] rsp_max_change_ff;
   logic                 rsp_last_ff;
   logic                 rsp_converged_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff      <= COL_BITS'(COLS_RESET);
         rows_ff      <= ROW_BITS'(ROWS_RESET);
         threshold_ff <= CELL_BITS'(THRESHOLD_RESET);
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_COLS:      cols_ff      <= csr_write_data[COL_BITS-1:0];
            CSR_ROWS:      rows_ff      <= csr_write_data[ROW_BITS-1:0];
            CSR_THRESHOLD: threshold_ff <= csr_write_data[CELL_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (cols_ff == '0) begin
         cols_eff = COL_BITS'(1);
      end else if (cols_ff > COL_BITS'(MAX_COLS)) begin
         cols_eff = COL_BITS'(MAX_COLS);
      end else begin
         cols_eff = cols_ff;
      end
      if (rows_ff == '0) begin
         rows_eff = ROW_BITS'(1);
      end else if (rows_ff > ROW_BITS'(MAX_ROWS)) begin
         rows_eff = ROW_BITS'(MAX_ROWS);
      end else begin
         rows_eff = rows_ff;
      end
      width_pad  = WIDE_BITS'(cols_eff) + WIDE_BITS'(2);
      height_pad = RPOS_BITS'(rows_eff) + RPOS_BITS'(2);
   end

   // request side: position, flags and wrap
   always_comb begin
      col0    = req_first_cell ? '0 : col_ff;
      row0    = req_first_cell ? '0 : row_ff;
      live    = row0 < height_pad;
      accept  = req_valid && !req_stall;
      enter   = accept && live;
      col_inc = WIDE_BITS'(col0) + WIDE_BITS'(1);
      wrap    = col_inc >= width_pad;

      flags_now.restart = req_first_cell;
      flags_now.emit    = (row0 >= RPOS_BITS'(2)) && (col0 != '0)
                        && (WIDE_BITS'(col0) <= WIDE_BITS'(cols_eff));
      flags_now.last    = (row0 == RPOS_BITS'(rows_eff) + RPOS_BITS'(1))
                        && (WIDE_BITS'(col0) == WIDE_BITS'(cols_eff));

      col_in = col_ff;
      row_in = row_ff;
      if (enter) begin
         col_in = wrap ? '0 : col_inc[POS_BITS-1:0];
         row_in = wrap ? row0 + RPOS_BITS'(1) : row0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // line one: written with the arriving cell, read at this and the next column
   always_ff @(posedge clock) begin
      if (enter) begin
         line_one_mem[col0] <= req_cell_value;
         mid_rd_ff          <= line_one_mem[col0];
         right_rd_ff        <= line_one_mem[col_inc[POS_BITS-1:0]];
      end
   end

   // line two: written back from the update stage, forwarded on a same-entry read
   always_ff @(posedge clock) begin
      if (s1_fire) begin
         line_two_mem[s1_col_ff] <= mid_rd_ff;
      end
      if (enter) begin
         up_rd_ff    <= line_two_mem[col0];
         fwd_hit_ff  <= s1_fire && (s1_col_ff == col0);
         fwd_data_ff <= mid_rd_ff;
      end
   end

   assign up_value = fwd_hit_ff ? fwd_data_ff : up_rd_ff;

   // update stage
   always_comb begin
      out_free    = !rsp_valid_ff || !rsp_stall;
      s1_fire     = s1_valid_ff && (!s1_flags_ff.emit || out_free);
      req_stall   = s1_valid_ff && !s1_fire;
      s1_valid_in = enter || (s1_valid_ff && !s1_fire);
      left_in        = s1_fire ? mid_rd_ff : left_ff;
      running_max_in = s1_fire ? max_next : running_max_ff;
      rsp_valid_in   = (s1_fire && s1_flags_ff.emit) || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         left_ff        <= '0;
         running_max_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         left_ff        <= left_in;
         running_max_ff <= running_max_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enter) begin
         s1_col_ff       <= col0;
         s1_row_index_ff <= ROW_BITS'(row0 - RPOS_BITS'(1));
         s1_cell_ff      <= req_cell_value;
         s1_flags_ff     <= flags_now;
      end
   end

   jls_point_update #(
      .CELL_BITS (CELL_BITS)
   ) u_point_update (
      .up_value     (up_value),
      .down_value   (s1_cell_ff),
      .left_value   (left_ff),
      .right_value  (right_rd_ff),
      .centre_value (mid_rd_ff),
      .running_max  (running_max_ff),
      .threshold    (threshold_ff),
      .flags        (s1_flags_ff),
      .new_value    (new_value),
      .cell_change  (cell_change),
      .max_next     (max_next),
      .converged    (converged)
   );

   // result register
   always_ff @(posedge clock) begin
      if (s1_fire && s1_flags_ff.emit) begin
         rsp_new_value_ff   <= new_value;
         rsp_cell_change_ff <= cell_change;
         rsp_row_index_ff   <= s1_row_index_ff;
         rsp_col_index_ff   <= COL_BITS'(s1_col_ff);
         rsp_max_change_ff  <= max_next;
         rsp_last_ff        <= s1_flags_ff.last;
         rsp_converged_ff   <= converged;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_new_value     = rsp_new_value_ff;
   assign rsp_cell_change   = rsp_cell_change_ff;
   assign rsp_row_index     = rsp_row_index_ff;
   assign rsp_col_index     = rsp_col_index_ff;
   assign rsp_max_change    = rsp_max_change_ff;
   assign rsp_last_of_sweep = rsp_last_ff;
   assign rsp_converged     = rsp_converged_ff;

endmodule

`default_nettype wire
